[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off while in reset.
`define SGDM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define SGDM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/sgdm_pkg.sv]
`timescale 1ns / 1ps

package sgdm_pkg;

    localparam int SGDM_PARAM_DEPTH = 4096;

    localparam int SGDM_IDX_W  = 12;
    localparam int SGDM_DW     = 32;
    localparam int SGDM_LR_W   = 32;
    localparam int SGDM_COEF_W = 25;
    localparam int SGDM_FRAC   = 24;
    localparam int SGDM_CFG_IW = 3;

    // full product widths: value times zero-extended coefficient
    localparam int SGDM_PC_W = SGDM_DW + SGDM_COEF_W + 1;
    localparam int SGDM_PL_W = SGDM_DW + SGDM_LR_W + 1;
    localparam int SGDM_PS_W = SGDM_PL_W + 1;
    localparam int SGDM_RW   = SGDM_PS_W - SGDM_FRAC;

    localparam logic [SGDM_CFG_IW-1:0] REG_LEARNING_RATE  = 3'd0;
    localparam logic [SGDM_CFG_IW-1:0] REG_MOMENTUM       = 3'd1;
    localparam logic [SGDM_CFG_IW-1:0] REG_WEIGHT_DECAY   = 3'd2;
    localparam logic [SGDM_CFG_IW-1:0] REG_REGULARIZER    = 3'd3;
    localparam logic [SGDM_CFG_IW-1:0] REG_GRADIENT_SCALE = 3'd4;

    localparam logic [SGDM_LR_W-1:0]   RST_LEARNING_RATE  = 32'd167772;
    localparam logic [SGDM_COEF_W-1:0] RST_MOMENTUM       = 25'd0;
    localparam logic [SGDM_COEF_W-1:0] RST_WEIGHT_DECAY   = 25'd0;
    localparam logic                   RST_REGULARIZER    = 1'b0;
    localparam logic [SGDM_COEF_W-1:0] RST_GRADIENT_SCALE = 25'd16777216;

    localparam logic                   REGU_L2 = 1'b0;

    localparam logic signed [SGDM_DW-1:0] SGDM_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SGDM_DW-1:0] SGDM_MIN = 32'sh8000_0000;
    localparam logic signed [SGDM_PS_W-1:0] SGDM_HALF = 66'sd8388608;

    typedef enum logic {
        SGDM_CLEAR,
        SGDM_RUN
    } sgdm_state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } sgdm_ram_ctl_t;

    // round half up at the binary point, then clamp to 32 bits
    function automatic logic signed [SGDM_DW-1:0] rnd_sat(
        input logic signed [SGDM_PL_W-1:0] p
    );
        logic signed [SGDM_PS_W-1:0] s;
        logic signed [SGDM_RW-1:0]   r;
        s = SGDM_PS_W'(p) + SGDM_HALF;
        r = $signed(s[SGDM_PS_W-1:SGDM_FRAC]);
        if (r > SGDM_RW'(SGDM_MAX))
            return SGDM_MAX;
        else if (r < SGDM_RW'(SGDM_MIN))
            return SGDM_MIN;
        else
            return r[SGDM_DW-1:0];
    endfunction

    function automatic logic signed [SGDM_DW-1:0] sat_add(
        input logic signed [SGDM_DW:0] s
    );
        if (s[SGDM_DW] != s[SGDM_DW-1])
            return s[SGDM_DW] ? SGDM_MIN : SGDM_MAX;
        else
            return s[SGDM_DW-1:0];
    endfunction

endpackage

[design/sgdm_in_if.sv]
`timescale 1ns / 1ps

interface sgdm_in_if;
    import sgdm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [SGDM_IDX_W-1:0]     element_index;
    logic signed [SGDM_DW-1:0] weight;
    logic signed [SGDM_DW-1:0] gradient;
    logic                      last;

    modport source (output valid, element_index, weight, gradient, last, input ready);
    modport sink (input valid, element_index, weight, gradient, last, output ready);
endinterface

[design/sgdm_out_if.sv]
`timescale 1ns / 1ps

interface sgdm_out_if;
    import sgdm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [SGDM_DW-1:0] new_weight;
    logic signed [SGDM_DW-1:0] update_value;
    logic                      last_out;

    modport source (output valid, new_weight, update_value, last_out, input ready);
    modport sink (input valid, new_weight, update_value, last_out, output ready);
endinterface

[design/sgdm_cfg_if.sv]
`timescale 1ns / 1ps

interface sgdm_cfg_if;
    import sgdm_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [SGDM_CFG_IW-1:0] index;
    logic [SGDM_DW-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[design/sgd_momentum_weight_update_core.sv]
`timescale 1ns / 1ps

// SGD weight update with momentum and weight decay, signed Q8.24 throughout.
// One item per cycle when not stalled; items pass stages s1 to s4, then the
// output register. The history of each element sits in a memory of PARAM_DEPTH
// words, with one read port and one write port, read two stages before its
// write-back; an item whose element_index equals that of the item in the
// first stage waits until that item moves on. After reset the memory is
// zeroed word by word, during which sample.ready is low; cfg is always ready
// and is meant to be written with the pipeline empty.
module sgd_momentum_weight_update_core #(
    parameter int PARAM_DEPTH = sgdm_pkg::SGDM_PARAM_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    sgdm_in_if.sink    sample,
    sgdm_out_if.source result,
    sgdm_cfg_if.sink   cfg
);
    import sgdm_pkg::*;

    localparam int AW = (PARAM_DEPTH > 1) ? $clog2(PARAM_DEPTH) : 1;

    // configuration
    logic [SGDM_LR_W-1:0]   lr_reg;
    logic [SGDM_COEF_W-1:0] mom_reg;
    logic [SGDM_COEF_W-1:0] wd_reg;
    logic                   regu_reg;
    logic [SGDM_COEF_W-1:0] gscale_reg;

    // pipeline control
    logic advance;
    logic hazard;
    logic accept;
    logic ram_busy;
    logic in_range;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic s1_inr_reg, s2_inr_reg, s3_inr_reg, s4_inr_reg;
    logic fwd_hit_reg;
    logic fwd_hit_next;

    // pipeline payload
    logic [SGDM_IDX_W-1:0]      s1_idx_reg, s2_idx_reg, s3_idx_reg, s4_idx_reg;
    logic signed [SGDM_DW-1:0]  s1_w_reg, s2_w_reg, s3_w_reg, s4_w_reg;
    logic                       s1_last_reg, s2_last_reg, s3_last_reg, s4_last_reg;
    logic signed [SGDM_DW-1:0]  s1_g_reg, s3_g_reg;
    logic signed [SGDM_PC_W-1:0] s2_gp_reg, s2_wp_reg, s4_hm_reg;
    logic signed [SGDM_PL_W-1:0] s4_gl_reg;
    logic signed [SGDM_DW-1:0]  fwd_data_reg;
    logic signed [SGDM_DW-1:0]  out_nw_reg, out_hn_reg;
    logic                       out_last_reg;

    logic signed [SGDM_PC_W-1:0] gp, wp, hm;
    logic signed [SGDM_PL_W-1:0] gl;
    logic signed [SGDM_DW-1:0]   g_scaled, g_dec, h_cur, hn, nw;
    logic signed [SGDM_DW:0]     decay_term;
    logic [SGDM_DW-1:0]          rd_data;
    sgdm_ram_ctl_t               ram_ctl;

    // configuration port
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lr_reg     <= RST_LEARNING_RATE;
            mom_reg    <= RST_MOMENTUM;
            wd_reg     <= RST_WEIGHT_DECAY;
            regu_reg   <= RST_REGULARIZER;
            gscale_reg <= RST_GRADIENT_SCALE;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_LEARNING_RATE:  lr_reg     <= cfg.data[SGDM_LR_W-1:0];
                REG_MOMENTUM:       mom_reg    <= cfg.data[SGDM_COEF_W-1:0];
                REG_WEIGHT_DECAY:   wd_reg     <= cfg.data[SGDM_COEF_W-1:0];
                REG_REGULARIZER:    regu_reg   <= cfg.data[0];
                REG_GRADIENT_SCALE: gscale_reg <= cfg.data[SGDM_COEF_W-1:0];
                default:            ;
            endcase
        end
    end

    // whole pipeline moves together; output register holds under back-pressure
    assign advance      = !out_valid_reg || result.ready;
    // keep two same-index items at least two stages apart for the read-modify-write
    assign hazard       = s1_valid_reg && (s1_idx_reg == sample.element_index);
    assign sample.ready = advance && !ram_busy && !hazard;
    assign accept       = sample.valid && sample.ready;
    assign in_range     = (32'(sample.element_index) < 32'(PARAM_DEPTH));

    // stage 1: gradient scale and L2 decay products
    assign gp = s1_g_reg * $signed({1'b0, gscale_reg});
    assign wp = s1_w_reg * $signed({1'b0, wd_reg});

    // stage 2: round, add decay
    always_comb
    begin
        g_scaled = rnd_sat(SGDM_PL_W'(s2_gp_reg));
        if (regu_reg == REGU_L2)
            decay_term = (SGDM_DW+1)'(rnd_sat(SGDM_PL_W'(s2_wp_reg)));
        else if (s2_w_reg > 0)
            decay_term = $signed({{(SGDM_DW+1-SGDM_COEF_W){1'b0}}, wd_reg});
        else if (s2_w_reg < 0)
            decay_term = -$signed({{(SGDM_DW+1-SGDM_COEF_W){1'b0}}, wd_reg});
        else
            decay_term = '0;
        g_dec = sat_add((SGDM_DW+1)'(g_scaled) + decay_term);
    end

    // stage 3: history from memory, from the write landing on the read edge, or zero out of range
    always_comb
    begin
        if (!s3_inr_reg)
            h_cur = '0;
        else if (fwd_hit_reg)
            h_cur = fwd_data_reg;
        else
            h_cur = $signed(rd_data);
    end

    assign hm = h_cur * $signed({1'b0, mom_reg});
    assign gl = s3_g_reg * $signed({1'b0, lr_reg});

    // stage 4: new history and weight
    assign hn = sat_add((SGDM_DW+1)'(rnd_sat(SGDM_PL_W'(s4_hm_reg)))
                      + (SGDM_DW+1)'(rnd_sat(s4_gl_reg)));
    assign nw = sat_add((SGDM_DW+1)'(s4_w_reg) - (SGDM_DW+1)'(hn));

    assign fwd_hit_next = s4_valid_reg && s4_inr_reg && (s4_idx_reg == s2_idx_reg);

    assign ram_ctl.rd_en = advance;
    assign ram_ctl.wr_en = advance && s4_valid_reg && s4_inr_reg;

    sgdm_hist_ram #(
        .DEPTH (PARAM_DEPTH),
        .AW    (AW)
    ) u_hist_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ram_ctl),
        .rd_addr (AW'(s2_idx_reg)),
        .wr_addr (AW'(s4_idx_reg)),
        .wr_data (hn),
        .rd_data (rd_data),
        .busy    (ram_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
            fwd_hit_reg   <= fwd_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_idx_reg   <= sample.element_index;
            s1_inr_reg   <= in_range;
            s1_w_reg     <= sample.weight;
            s1_g_reg     <= sample.gradient;
            s1_last_reg  <= sample.last;

            s2_idx_reg   <= s1_idx_reg;
            s2_inr_reg   <= s1_inr_reg;
            s2_w_reg     <= s1_w_reg;
            s2_last_reg  <= s1_last_reg;
            s2_gp_reg    <= gp;
            s2_wp_reg    <= wp;

            s3_idx_reg   <= s2_idx_reg;
            s3_inr_reg   <= s2_inr_reg;
            s3_w_reg     <= s2_w_reg;
            s3_last_reg  <= s2_last_reg;
            s3_g_reg     <= g_dec;

            s4_idx_reg   <= s3_idx_reg;
            s4_inr_reg   <= s3_inr_reg;
            s4_w_reg     <= s3_w_reg;
            s4_last_reg  <= s3_last_reg;
            s4_hm_reg    <= hm;
            s4_gl_reg    <= gl;

            fwd_data_reg <= hn;

            out_nw_reg   <= nw;
            out_hn_reg   <= hn;
            out_last_reg <= s4_last_reg;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.new_weight   = out_nw_reg;
    assign result.update_value = out_hn_reg;
    assign result.last_out     = out_last_reg;

endmodule

[design/sgdm_hist_ram.sv]
`timescale 1ns / 1ps

module sgdm_hist_ram #(
    parameter int DEPTH = sgdm_pkg::SGDM_PARAM_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sgdm_pkg::sgdm_ram_ctl_t      ctl,
    input  logic [AW-1:0]                rd_addr,
    input  logic [AW-1:0]                wr_addr,
    input  logic [sgdm_pkg::SGDM_DW-1:0] wr_data,
    output logic [sgdm_pkg::SGDM_DW-1:0] rd_data,
    output logic                         busy
);
    import sgdm_pkg::*;

    logic [SGDM_DW-1:0] mem [DEPTH];
    logic [SGDM_DW-1:0] rd_data_reg;

    sgdm_state_t   state_reg;
    sgdm_state_t   state_next;
    logic [AW-1:0] cnt_reg;
    logic [AW-1:0] cnt_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SGDM_CLEAR:
            begin
                if (cnt_reg == AW'(DEPTH - 1))
                    state_next = SGDM_RUN;
            end
            SGDM_RUN:
            begin
                state_next = SGDM_RUN;
            end
            default:
            begin
                state_next = SGDM_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        busy     = 1'b0;
        cnt_next = cnt_reg;
        unique case (state_reg)
            SGDM_CLEAR:
            begin
                busy     = 1'b1;
                cnt_next = cnt_reg + AW'(1);
            end
            SGDM_RUN:
            begin
                busy = 1'b0;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SGDM_CLEAR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // zeroing sweep after reset, then the pipeline's write-back port
    always_ff @(posedge clk)
    begin
        if (busy)
            mem[cnt_reg] <= '0;
        else if (ctl.wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[design/sgdm_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sgdm_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              sample_valid,
    input logic                              sample_ready,
    input logic [sgdm_pkg::SGDM_IDX_W-1:0]   sample_index,
    input logic                              result_valid,
    input logic                              result_ready,
    input logic signed [sgdm_pkg::SGDM_DW-1:0] result_new_weight,
    input logic signed [sgdm_pkg::SGDM_DW-1:0] result_update_value,
    input logic                              result_last_out
);
    import sgdm_pkg::*;

    localparam int MAX_IN_FLIGHT = 5;

    logic       take;
    logic       give;
    logic [3:0] occ_reg;
    logic [3:0] occ_next;

    assign take = sample_valid && sample_ready;
    assign give = result_valid && result_ready;

    always_comb
    begin
        occ_next = occ_reg;
        if (take && !give)
            occ_next = occ_reg + 4'd1;
        else if (give && !take)
            occ_next = occ_reg - 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else
            occ_reg <= occ_next;
    end

    `SGDM_ASSERT_NXT(a_result_held, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result_new_weight) && $stable(result_update_value) && $stable(result_last_out))
    `SGDM_ASSERT_IMP(a_no_orphan_result, clk, rst_n, result_valid, occ_reg != 4'd0)
    `SGDM_ASSERT_IMP(a_bounded_in_flight, clk, rst_n, 1'b1, occ_reg <= 4'(MAX_IN_FLIGHT))
    `SGDM_ASSERT_IMP(a_same_index_spaced, clk, rst_n, take && $past(take), sample_index != $past(sample_index))

endmodule

bind sgd_momentum_weight_update_core sgdm_checker u_sgdm_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .sample_valid        (sample.valid),
    .sample_ready        (sample.ready),
    .sample_index        (sample.element_index),
    .result_valid        (result.valid),
    .result_ready        (result.ready),
    .result_new_weight   (result.new_weight),
    .result_update_value (result.update_value),
    .result_last_out     (result.last_out)
);
